// ===== design/sitd_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none

package sitd_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int DIGIT_COUNT = 10;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);

  localparam logic [CHAR_W-1:0]  MINUS_CODE = 8'h2D;
  localparam logic [CHAR_W-1:0]  ZERO_CODE  = 8'h30;

  // Multiply by this and shift right to divide a 32-bit value by ten exactly.
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

endpackage

`default_nettype wire

// ===== design/sitd_front.sv =====
// Input stage: accepts a value and splits it into sign and unsigned magnitude.
`default_nettype none

module sitd_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sitd_pkg::VALUE_W-1:0]    in_value,
  output logic                                   push_valid,
  input  logic                                   push_ready,
  output sitd_pkg::item_t                        push_item
);
  import sitd_pkg::*;

  logic  hold_r;
  logic  hold_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  take;

  assign in_ready   = !hold_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = hold_r;
  assign push_item  = item_r;

  always_comb begin
    hold_nxt = hold_r;
    item_nxt = item_r;
    if (take) begin
      hold_nxt     = 1'b1;
      item_nxt.neg = in_value[VALUE_W-1];
      item_nxt.mag = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                         : VALUE_W'(in_value);
    end else if (push_ready) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

// ===== design/sitd_queue.sv =====
// Small queue that decouples the input stage from the conversion engine.
`default_nettype none

module sitd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  sitd_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output sitd_pkg::item_t pop_item
);
  import sitd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/sitd_back.sv =====
// Conversion engine: peels off decimal digits, then emits the text one character at a time.
`default_nettype none

module sitd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  sitd_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sitd_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_last_char
);
  import sitd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                 state_r;
  state_t                 state_nxt;
  logic [VALUE_W-1:0]     mag_r;
  logic [VALUE_W-1:0]     mag_nxt;
  logic                   sign_pend_r;
  logic                   sign_pend_nxt;
  logic [DIGIT_IDX_W-1:0] nd_r;
  logic [DIGIT_IDX_W-1:0] nd_nxt;
  logic [DIGIT_IDX_W-1:0] idx_r;
  logic [DIGIT_IDX_W-1:0] idx_nxt;
  logic [DIGIT_W-1:0]     digits_r [DIGIT_COUNT];
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r;
  logic [CHAR_W-1:0]      out_char_nxt;
  logic                   out_last_r;
  logic                   out_last_nxt;

  logic [2*VALUE_W-1:0]   prod;
  logic [VALUE_W-1:0]     quot;
  logic [DIGIT_W-1:0]     ten_q_lo;
  logic [DIGIT_W-1:0]     digit;
  logic                   slot_free;

  // The remainder is below ten, so only the low four bits of the subtraction matter.
  assign prod     = {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quot     = {{(RECIP_SHIFT - VALUE_W){1'b0}}, prod[2*VALUE_W-1:RECIP_SHIFT]};
  assign ten_q_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign digit    = mag_r[DIGIT_W-1:0] - ten_q_lo;

  assign slot_free     = !out_valid_r || out_ready;
  assign q_pop         = (state_r == ST_IDLE) && q_valid;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    sign_pend_nxt = sign_pend_r;
    nd_nxt        = nd_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          mag_nxt       = q_item.mag;
          sign_pend_nxt = q_item.neg;
          nd_nxt        = '0;
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt = quot;
        nd_nxt  = nd_r + 1'b1;
        if (quot == '0) begin
          idx_nxt   = nd_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = MINUS_CODE;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = ZERO_CODE | {{(CHAR_W - DIGIT_W){1'b0}}, digits_r[idx_r]};
            out_last_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    sign_pend_r <= sign_pend_nxt;
    nd_r        <= nd_nxt;
    idx_r       <= idx_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    if (state_r == ST_CONV) begin
      digits_r[nd_r] <= digit;
    end
  end

endmodule

`default_nettype wire

// ===== design/signed_int_to_decimal_text.sv =====
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// The input channel takes one signed 32-bit value per transaction on in_value.
// The output channel returns its decimal text, one ASCII character per
// transaction on out_char_code, most significant digit first, with a leading
// minus sign for negative values and out_last_char set on the final character.
// Zero gives the single character '0'; the most negative value gives
// "-2147483648".
// An input register and a small queue sit ahead of the conversion engine, so
// values are accepted while earlier text is still being produced.
// The engine picks up a value, runs its divide-by-ten loop once per digit,
// then sends each character through the output register, the minus sign
// first; it takes no new value from the queue until the last character has
// entered that register.
// When out_ready is low the current character holds and the engine waits;
// the queue fills and then in_ready falls.
// A synchronous reset on rst_n empties the queue and drops any pending text.
`default_nettype none

module signed_int_to_decimal_text #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sitd_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sitd_pkg::CHAR_W-1:0]         out_char_code,
  output logic                                out_last_char
);
  import sitd_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  sitd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sitd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  sitd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (pop_valid),
    .q_pop         (pop),
    .q_item        (pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

// ===== design/sitd_checker.sv =====
// Port-level checks for the converter, bound to its top level.
`default_nettype none

module sitd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [sitd_pkg::VALUE_W-1:0] in_value,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [sitd_pkg::CHAR_W-1:0]         out_char_code,
  input logic                                out_last_char
);
  import sitd_pkg::*;

  logic in_seen;

  assign in_seen = in_valid && in_ready && (in_value == in_value);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last_char))
    else $error("Stalled output transaction changed or dropped.");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == MINUS_CODE) ||
                  (out_char_code >= ZERO_CODE && out_char_code <= ZERO_CODE + 8'd9))
    else $error("Output character is neither a minus sign nor a digit.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == MINUS_CODE |-> !out_last_char)
    else $error("Minus sign marked as the last character.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !$past(in_seen && rst_n))
    else $error("Output valid right after reset.");

endmodule

bind signed_int_to_decimal_text sitd_checker u_sitd_checker (.*);

`default_nettype wire
